@@ rtl/sws_pkg.sv @@
// Shared types and constants of the shell word splitter.
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_WEND = 2'd1,
		KIND_OK   = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	// characters the scanner reacts to
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one result
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// queue entry: the one or two results of one input item
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

endpackage
`default_nettype wire

@@ rtl/sws_front.sv @@
// Front end: scan mode machine that classifies each byte into its results.
`timescale 1ns / 1ps
`default_nettype none
module sws_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire logic [7:0]     in_byte,
	input  wire logic           end_of_input,
	output logic                q_push,
	output sws_pkg::entry_t     q_entry
);

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_SQ     = 3'd2,
		MODE_DQ     = 3'd3,
		MODE_DQ_ESC = 3'd4
	} mode_t;

	mode_t mode_q, mode_d;
	logic  word_open_q, word_open_d;
	logic [1:0] nres;
	sws_pkg::res_t r0, r1;

	// next mode and the results of this byte
	always_comb begin
		mode_d      = mode_q;
		word_open_d = word_open_q;
		nres        = 2'd0;
		r0          = '{kind: sws_pkg::KIND_CHAR, data: 8'h00};
		r1          = '{kind: sws_pkg::KIND_CHAR, data: 8'h00};
		if (end_of_input) begin
			if (mode_q == MODE_PLAIN) begin
				if (word_open_q) begin
					r0.kind = sws_pkg::KIND_WEND;
					r1.kind = sws_pkg::KIND_OK;
					nres    = 2'd2;
				end else begin
					r0.kind = sws_pkg::KIND_OK;
					nres    = 2'd1;
				end
			end else if (mode_q == MODE_ESC || mode_q == MODE_SQ ||
				mode_q == MODE_DQ || mode_q == MODE_DQ_ESC) begin
				r0.kind = sws_pkg::KIND_ERR;
				nres    = 2'd1;
			end else begin
				// unused codes act as plain
				if (word_open_q) begin
					r0.kind = sws_pkg::KIND_WEND;
					r1.kind = sws_pkg::KIND_OK;
					nres    = 2'd2;
				end else begin
					r0.kind = sws_pkg::KIND_OK;
					nres    = 2'd1;
				end
			end
			mode_d      = MODE_PLAIN;
			word_open_d = 1'b0;
		end else begin
			case (mode_q)
				MODE_ESC: begin
					mode_d = MODE_PLAIN;
					if (in_byte != sws_pkg::CH_NL) begin
						r0.data     = in_byte;
						nres        = 2'd1;
						word_open_d = 1'b1;
					end
				end
				MODE_SQ: begin
					if (in_byte == sws_pkg::CH_SQUOTE) begin
						mode_d = MODE_PLAIN;
						if (!word_open_q) begin
							r0.kind = sws_pkg::KIND_WEND;
							nres    = 2'd1;
						end
					end else begin
						r0.data     = in_byte;
						nres        = 2'd1;
						word_open_d = 1'b1;
					end
				end
				MODE_DQ: begin
					if (in_byte == sws_pkg::CH_DQUOTE) begin
						mode_d = MODE_PLAIN;
						if (!word_open_q) begin
							r0.kind = sws_pkg::KIND_WEND;
							nres    = 2'd1;
						end
					end else if (in_byte == sws_pkg::CH_BSLASH) begin
						mode_d = MODE_DQ_ESC;
					end else begin
						r0.data     = in_byte;
						nres        = 2'd1;
						word_open_d = 1'b1;
					end
				end
				MODE_DQ_ESC: begin
					mode_d = MODE_DQ;
					if (in_byte == sws_pkg::CH_NL) begin
						// line continuation
					end else if (in_byte == sws_pkg::CH_DQUOTE ||
						in_byte == sws_pkg::CH_BSLASH) begin
						r0.data     = in_byte;
						nres        = 2'd1;
						word_open_d = 1'b1;
					end else begin
						// keep the backslash and the byte
						r0.data     = sws_pkg::CH_BSLASH;
						r1.data     = in_byte;
						nres        = 2'd2;
						word_open_d = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_PLAIN;
					if (in_byte == sws_pkg::CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else if (in_byte == sws_pkg::CH_DQUOTE) begin
						mode_d = MODE_DQ;
					end else if (in_byte == sws_pkg::CH_SQUOTE) begin
						mode_d = MODE_SQ;
					end else if (in_byte == sws_pkg::CH_SPACE ||
						in_byte == sws_pkg::CH_TAB) begin
						if (word_open_q) begin
							r0.kind     = sws_pkg::KIND_WEND;
							nres        = 2'd1;
							word_open_d = 1'b0;
						end
					end else begin
						r0.data     = in_byte;
						nres        = 2'd1;
						word_open_d = 1'b1;
					end
				end
			endcase
		end
	end

	assign q_push        = fire && (nres != 2'd0);
	assign q_entry.two   = (nres == 2'd2);
	assign q_entry.r0    = r0;
	assign q_entry.r1    = r1;

	// mode and word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PLAIN;
			word_open_q <= 1'b0;
		end else if (fire) begin
			mode_q      <= mode_d;
			word_open_q <= word_open_d;
		end
	end

	// end of input leaves a clean scanner
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_input |=> mode_q == MODE_PLAIN && !word_open_q)
		else $error("scanner not cleared after end of input");

	// every byte and terminator of a string yields at most one status, as its final result
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_entry.two |-> q_entry.r0.kind == sws_pkg::KIND_CHAR ||
			q_entry.r0.kind == sws_pkg::KIND_WEND)
		else $error("status result placed before another result");

endmodule
`default_nettype wire

@@ rtl/sws_queue.sv @@
// Short queue of result entries between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module sws_queue #(
	parameter int DEPTH = sws_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire sws_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	output sws_pkg::entry_t      rd_data,
	output logic                 q_full,
	output logic                 q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sws_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full  = (count_q == FULL_CNT);
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue fill count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

@@ rtl/sws_back.sv @@
// Back end: expands queued entries into single results in an output register.
`timescale 1ns / 1ps
`default_nettype none
module sws_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire sws_pkg::entry_t q_data,
	output logic                 q_pop,
	input  wire logic            pop,
	output logic                 empty,
	output logic [1:0]           kind,
	output logic [7:0]           out_byte,
	output logic                 last
);

	logic          out_v_q;
	logic          sel_q;
	logic          load;
	sws_pkg::res_t out_q;
	logic          last_q;
	logic          first_of_two;

	assign load         = q_valid && (!out_v_q || pop);
	assign first_of_two = q_data.two && !sel_q;
	assign q_pop        = load && !first_of_two;

	// output register and position within the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				sel_q   <= first_of_two;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= sel_q ? q_data.r1 : q_data.r0;
			last_q <= !first_of_two;
		end
	end

	assign empty    = !out_v_q;
	assign kind     = out_q.kind;
	assign out_byte = out_q.data;
	assign last     = last_q;

	// a status always closes its item
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == sws_pkg::KIND_OK || kind == sws_pkg::KIND_ERR) |-> last)
		else $error("status result not marked last");

	// second half of an entry is pending only while the entry is still queued
	a_sel_pending: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> q_valid && q_data.two)
		else $error("second result pending without its entry");

endmodule
`default_nettype wire

@@ rtl/shell_word_splitter_unit.sv @@
// Shell word splitter: top level joining scanner, queue and result stage.
// Order: with queue and output stage empty, an accepted item goes into the queue, then into the
// output register; the second result of an item follows in the cycle after the first is taken.
// Throughput: one item per cycle while not full; the result stage gives one result per cycle
// while popped, so a two-result item holds it longer and the queue absorbs the difference.
// Reset (arst_n low, asynchronous): plain mode, no word open, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module shell_word_splitter_unit #(
	parameter int QDEPTH = sws_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      kind,
	output logic [7:0]      out_byte,
	output logic            last
);

	logic            fire;
	logic            q_push;
	logic            q_pop;
	logic            q_empty;
	sws_pkg::entry_t wr_entry;
	sws_pkg::entry_t rd_entry;

	assign fire = push && !full;

	sws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.q_push       (q_push),
		.q_entry      (wr_entry)
	);

	sws_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (wr_entry),
		.rd_en   (q_pop),
		.rd_data (rd_entry),
		.q_full  (full),
		.q_empty (q_empty)
	);

	sws_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_empty),
		.q_data   (rd_entry),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.kind     (kind),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule
`default_nettype wire

@@ verif/shell_word_splitter_checker.sv @@
// Checker for the shell word splitter: predicts results per accepted item and compares them.
`timescale 1ns / 1ps
module shell_word_splitter_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       full,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	input  wire logic       empty,
	input  wire logic       pop,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] out_byte,
	input  wire logic       last,
	output int              fail_count,
	output int              pending
);

	// scanner modes of the predictor
	typedef enum logic [2:0] {
		SCAN_PLAIN  = 3'd0,
		SCAN_ESC    = 3'd1,
		SCAN_SQ     = 3'd2,
		SCAN_DQ     = 3'd3,
		SCAN_DQ_ESC = 3'd4
	} scan_mode_t;

	typedef struct packed {
		sws_pkg::kind_t kind;
		logic [7:0]     data;
		logic           last;
	} word_result_t;

	scan_mode_t   scan_mode = SCAN_PLAIN;
	logic         word_open = 1'b0;
	word_result_t expected_results[$];
	word_result_t staged[2];
	int           staged_n;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// collect one result of the current item; at most two per item
	function automatic void stage(sws_pkg::kind_t k, logic [7:0] b);
		if (staged_n < 2) begin
			staged[staged_n] = '{k, (k == sws_pkg::KIND_CHAR) ? b : 8'h00, 1'b0};
			staged_n++;
		end
	endfunction

	function automatic void put_char(logic [7:0] b);
		stage(sws_pkg::KIND_CHAR, b);
		word_open = 1'b1;
	endfunction

	// a closing quote gives an empty word only if nothing is in the word yet
	function automatic void close_quote();
		scan_mode = SCAN_PLAIN;
		if (!word_open)
			stage(sws_pkg::KIND_WEND, 8'h00);
	endfunction

	// advance the scanner by one item and queue what it yields
	function automatic void split_item(logic [7:0] c, logic eoi);
		staged_n = 0;
		if (eoi) begin
			if (scan_mode != SCAN_PLAIN) begin
				stage(sws_pkg::KIND_ERR, 8'h00);
			end else begin
				if (word_open)
					stage(sws_pkg::KIND_WEND, 8'h00);
				stage(sws_pkg::KIND_OK, 8'h00);
			end
			scan_mode = SCAN_PLAIN;
			word_open = 1'b0;
		end else begin
			case (scan_mode)
				SCAN_ESC: begin
					scan_mode = SCAN_PLAIN;
					if (c != sws_pkg::CH_NL)
						put_char(c);
				end
				SCAN_SQ: begin
					if (c == sws_pkg::CH_SQUOTE)
						close_quote();
					else
						put_char(c);
				end
				SCAN_DQ: begin
					if (c == sws_pkg::CH_DQUOTE)
						close_quote();
					else if (c == sws_pkg::CH_BSLASH)
						scan_mode = SCAN_DQ_ESC;
					else
						put_char(c);
				end
				SCAN_DQ_ESC: begin
					scan_mode = SCAN_DQ;
					if (c == sws_pkg::CH_NL) begin
						// line continuation yields nothing
					end else if (c == sws_pkg::CH_DQUOTE || c == sws_pkg::CH_BSLASH) begin
						put_char(c);
					end else begin
						put_char(sws_pkg::CH_BSLASH);
						put_char(c);
					end
				end
				default: begin
					scan_mode = SCAN_PLAIN;
					if (c == sws_pkg::CH_BSLASH)
						scan_mode = SCAN_ESC;
					else if (c == sws_pkg::CH_DQUOTE)
						scan_mode = SCAN_DQ;
					else if (c == sws_pkg::CH_SQUOTE)
						scan_mode = SCAN_SQ;
					else if (c == sws_pkg::CH_SPACE || c == sws_pkg::CH_TAB) begin
						if (word_open) begin
							stage(sws_pkg::KIND_WEND, 8'h00);
							word_open = 1'b0;
						end
					end else
						put_char(c);
				end
			endcase
		end
		if (staged_n > 0)
			staged[staged_n - 1].last = 1'b1;
		for (int i = 0; i < staged_n; i++)
			expected_results.push_back(staged[i]);
	endfunction

	function automatic void report_mismatch(string what, word_result_t want,
		word_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch (%s): expected kind %0d byte %02h last %0b, %s %0d %s %02h %s %0b",
				what, want.kind, want.data, want.last,
				"got kind", got.kind, "byte", got.data, "last", got.last);
	endfunction

	// results are checked before the same edge's item is predicted: an item never
	// shows its result at the edge that accepts it
	always @(posedge clk or negedge arst_n) begin
		word_result_t got;
		word_result_t want;
		if (!arst_n) begin
			scan_mode = SCAN_PLAIN;
			word_open = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (pop && !empty) begin
				got = '{sws_pkg::kind_t'(kind), out_byte, last};
				if (expected_results.size() == 0) begin
					report_mismatch("no item expected", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.data !== want.data ||
						got.last !== want.last)
						report_mismatch("wrong field", want, got);
				end
			end
			if (push && !full)
				split_item(in_byte, end_of_input);
			pending = expected_results.size();
		end
	end

endmodule

@@ verif/shell_word_splitter_unit_test.sv @@
// Testbench top of the shell word splitter: stimulus, idling, stall pressure and verdict.
`timescale 1ns / 1ps
module shell_word_splitter_unit_test;

	localparam int TOTAL_ITEMS = 650;
	localparam int HOLD_CYCLES = 300;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       push         = 1'b0;
	logic [7:0] in_byte      = 8'h00;
	logic       end_of_input = 1'b0;
	logic       pop          = 1'b0;
	logic       full;
	logic       empty;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;

	int fail_count;
	int pending;
	int send_idle_pct = 9;
	int recv_idle_pct = 64;
	bit hold_request  = 1'b0;
	int items_sent    = 0;

	shell_word_splitter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.out_byte     (out_byte),
		.last         (last)
	);

	shell_word_splitter_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.out_byte     (out_byte),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// offer one item, with random idle cycles first; returns at the accepting edge
	task automatic send_item(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		in_byte      <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// a whole string followed by its terminator (byte under the terminator is random)
	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// raw character biased towards the bytes the scanner reacts to
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return 8'(8'h61 + $urandom_range(25));
		else if (r < 45)
			return $urandom_range(1) ? sws_pkg::CH_SPACE : sws_pkg::CH_TAB;
		else if (r < 55)
			return sws_pkg::CH_BSLASH;
		else if (r < 64)
			return sws_pkg::CH_DQUOTE;
		else if (r < 73)
			return sws_pkg::CH_SQUOTE;
		else if (r < 80)
			return sws_pkg::CH_NL;
		else
			return 8'($urandom_range(255));
	endfunction

	// mostly well-formed command strings built from tokens, some raw noise
	task automatic send_random_string();
		logic [7:0] c;
		int ntok;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(8)) send_item(pick_char(), 1'b0);
			send_item(8'($urandom_range(255)), 1'b1);
		end else begin
			ntok = $urandom_range(6);
			repeat (ntok) begin
				case ($urandom_range(5))
					0: repeat ($urandom_range(4, 1))
						send_item(8'(8'h61 + $urandom_range(25)), 1'b0);
					1: repeat ($urandom_range(2, 1))
						send_item($urandom_range(1) ? sws_pkg::CH_SPACE : sws_pkg::CH_TAB, 1'b0);
					2: begin
						send_item(sws_pkg::CH_SQUOTE, 1'b0);
						repeat ($urandom_range(3)) begin
							c = 8'($urandom_range(255));
							if (c == sws_pkg::CH_SQUOTE)
								c = 8'h61;
							send_item(c, 1'b0);
						end
						send_item(sws_pkg::CH_SQUOTE, 1'b0);
					end
					3: begin
						send_item(sws_pkg::CH_DQUOTE, 1'b0);
						repeat ($urandom_range(3)) begin
							case ($urandom_range(3))
								0: send_item(8'(8'h41 + $urandom_range(25)), 1'b0);
								1: begin
									send_item(sws_pkg::CH_BSLASH, 1'b0);
									case ($urandom_range(3))
										0: send_item(sws_pkg::CH_DQUOTE, 1'b0);
										1: send_item(sws_pkg::CH_BSLASH, 1'b0);
										2: send_item(sws_pkg::CH_NL, 1'b0);
										default: send_item(8'($urandom_range(255)), 1'b0);
									endcase
								end
								default: begin
									c = 8'($urandom_range(255));
									if (c == sws_pkg::CH_DQUOTE || c == sws_pkg::CH_BSLASH)
										c = sws_pkg::CH_SPACE;
									send_item(c, 1'b0);
								end
							endcase
						end
						send_item(sws_pkg::CH_DQUOTE, 1'b0);
					end
					4: begin
						send_item(sws_pkg::CH_BSLASH, 1'b0);
						send_item($urandom_range(1) ? sws_pkg::CH_NL : 8'($urandom_range(255)),
							1'b0);
					end
					default: send_item(8'($urandom_range(255)), 1'b0);
				endcase
			end
			send_item(8'($urandom_range(255)), 1'b1);
		end
	endtask

	// receiver: random pop, with one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stimulus and verdict
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, escapes, separators, empty words, quote handling
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		send_string("\\\nx\t\\y");
		send_string("''");
		send_string("a\"\\\"\\q\\\n\"");
		send_string("'");

		// random phases: receiver lazy, then sender lazy, then neither
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_request  = 1'b1;
				end
			endcase
			while (items_sent < 25 + (phase + 1) * (TOTAL_ITEMS - 25) / 3)
				send_random_string();
		end
		push <= 1'b0;

		// drain, then allow for anything still in flight
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
